>>> hdl/rlfe_pkg.sv
// Shared types, constants and the control store of the RGB fade engine.
// Used by the top level and by the iterative divider; depends on nothing.
package rlfe_pkg;

  localparam int CHANNELS  = 3;
  localparam int COLOR_W   = 8;
  localparam int STEP_W    = 8;
  localparam int DELAY_W   = 16;
  localparam int SCALE_SH  = 7;                      // scale of 128
  localparam int ACC_W     = COLOR_W + SCALE_SH;     // 15-bit accumulator
  localparam int INC_W     = ACC_W + 2;              // 17-bit signed increment
  localparam int DIV_W     = ACC_W;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PC_W      = 4;

  localparam logic [ACC_W-1:0] ACC_MAX = ACC_W'(255 * 128);
  localparam logic [CH_W-1:0]  CH_LAST = CH_W'(CHANNELS - 1);

  localparam logic OPC_START = 1'b0;
  localparam logic OPC_TICK  = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [COLOR_W-1:0] target_red;
    logic [COLOR_W-1:0] target_green;
    logic [COLOR_W-1:0] target_blue;
    logic [STEP_W-1:0]  fade_steps;
    logic [DELAY_W-1:0] step_delay_ms;
  } in_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red_level;
    logic [COLOR_W-1:0] green_level;
    logic [COLOR_W-1:0] blue_level;
    logic               fading;
  } out_item_t;

  // Datapath action of one control step.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,       // latch targets, clear channel index
    OP_DIV_GO,     // launch divide for the current channel
    OP_STORE_INC,  // store increment and preset accumulator, next channel
    OP_ARM,        // apply first step and arm the step timer
    OP_TICK_DEC,   // count down one millisecond
    OP_STEP,       // apply one step and reload the timer
    OP_SNAP        // jump to the target colour and go idle
  } step_op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ACCEPT,
    C_TICK,
    C_ZERO_STEPS,
    C_DIV_BUSY,
    C_CH_MORE,
    C_NOT_BUSY,
    C_MS_NONZERO,
    C_STEPS_ZERO,
    C_OUT_BLOCKED
  } jump_cond_t;

  typedef struct packed {
    step_op_t        op;
    logic            emit;
    jump_cond_t      cond;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
  localparam logic [PC_W-1:0] PC_DISPATCH = 4'd1;
  localparam logic [PC_W-1:0] PC_LOAD     = 4'd2;
  localparam logic [PC_W-1:0] PC_DIV_GO   = 4'd3;
  localparam logic [PC_W-1:0] PC_DIV_WAIT = 4'd4;
  localparam logic [PC_W-1:0] PC_STORE    = 4'd5;
  localparam logic [PC_W-1:0] PC_ARM      = 4'd6;
  localparam logic [PC_W-1:0] PC_SPARE    = 4'd7;
  localparam logic [PC_W-1:0] PC_TICK     = 4'd8;
  localparam logic [PC_W-1:0] PC_DEC      = 4'd9;
  localparam logic [PC_W-1:0] PC_EXPIRED  = 4'd10;
  localparam logic [PC_W-1:0] PC_LASTCHK  = 4'd11;
  localparam logic [PC_W-1:0] PC_STEP     = 4'd12;
  localparam logic [PC_W-1:0] PC_SNAP     = 4'd13;
  localparam logic [PC_W-1:0] PC_EMIT     = 4'd14;
  localparam logic [PC_W-1:0] PC_WRAP     = 4'd15;

  // Control store: on a true condition jump to target, else fall through.
  function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
    ctrl_word_t cw;
    cw = '{op: OP_NOP, emit: 1'b0, cond: C_ALWAYS, target: PC_IDLE};
    case (pc)
      PC_IDLE:     cw = '{op: OP_NOP,       emit: 1'b0, cond: C_NO_ACCEPT,   target: PC_IDLE};
      PC_DISPATCH: cw = '{op: OP_NOP,       emit: 1'b0, cond: C_TICK,        target: PC_TICK};
      PC_LOAD:     cw = '{op: OP_LOAD,      emit: 1'b0, cond: C_ZERO_STEPS,  target: PC_SNAP};
      PC_DIV_GO:   cw = '{op: OP_DIV_GO,    emit: 1'b0, cond: C_NEVER,       target: PC_IDLE};
      PC_DIV_WAIT: cw = '{op: OP_NOP,       emit: 1'b0, cond: C_DIV_BUSY,    target: PC_DIV_WAIT};
      PC_STORE:    cw = '{op: OP_STORE_INC, emit: 1'b0, cond: C_CH_MORE,     target: PC_DIV_GO};
      PC_ARM:      cw = '{op: OP_ARM,       emit: 1'b0, cond: C_ALWAYS,      target: PC_EMIT};
      PC_SPARE:    cw = '{op: OP_NOP,       emit: 1'b0, cond: C_ALWAYS,      target: PC_IDLE};
      PC_TICK:     cw = '{op: OP_NOP,       emit: 1'b0, cond: C_NOT_BUSY,    target: PC_EMIT};
      PC_DEC:      cw = '{op: OP_TICK_DEC,  emit: 1'b0, cond: C_NEVER,       target: PC_IDLE};
      PC_EXPIRED:  cw = '{op: OP_NOP,       emit: 1'b0, cond: C_MS_NONZERO,  target: PC_EMIT};
      PC_LASTCHK:  cw = '{op: OP_NOP,       emit: 1'b0, cond: C_STEPS_ZERO,  target: PC_SNAP};
      PC_STEP:     cw = '{op: OP_STEP,      emit: 1'b0, cond: C_ALWAYS,      target: PC_EMIT};
      PC_SNAP:     cw = '{op: OP_SNAP,      emit: 1'b0, cond: C_NEVER,       target: PC_IDLE};
      PC_EMIT:     cw = '{op: OP_NOP,       emit: 1'b1, cond: C_OUT_BLOCKED, target: PC_EMIT};
      PC_WRAP:     cw = '{op: OP_NOP,       emit: 1'b0, cond: C_ALWAYS,      target: PC_IDLE};
      default:     cw = '{op: OP_NOP,       emit: 1'b0, cond: C_ALWAYS,      target: PC_IDLE};
    endcase
    return cw;
  endfunction

endpackage

>>> hdl/rlfe_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on rlfe_pkg for the dividend and divisor widths.
module rlfe_div import rlfe_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DIV_W-1:0]   dividend,
  input  logic [STEP_W-1:0]  divisor,
  output logic               busy,
  output logic [DIV_W-1:0]   quotient
);

  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [STEP_W-1:0]    rem_r, rem_nxt;
  logic [STEP_W-1:0]    dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [STEP_W:0]      shifted;
  logic [STEP_W:0]      trial;
  logic                 fits;

  always_comb begin
    shifted = {rem_r, quo_r[DIV_W-1]};
    trial   = shifted - {1'b0, dvs_r};
    fits    = (shifted >= {1'b0, dvs_r});
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = DIV_CNT_W'(DIV_W);
    end else if (cnt_r != '0) begin
      quo_nxt = {quo_r[DIV_W-2:0], fits};
      rem_nxt = fits ? trial[STEP_W-1:0] : shifted[STEP_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = (cnt_r != '0);
  assign quotient = quo_r;

endmodule

>>> hdl/rgb_linear_fade_engine_unit.sv
// RGB linear fade engine: one result per input item, start commands and 1 ms ticks.
// A microcoded step counter runs the datapath; the per-channel increment comes from
// rlfe_div, and all types and the control store come from rlfe_pkg.
//
// One item is worked on at a time. An idle tick goes from dispatch straight to the
// result; a tick that only counts down also passes the decrement and expiry check, and
// one that applies a step or snaps also the last-step check; a start with zero steps
// snaps at once. A fading start runs the divider once per channel, one after the other,
// each as a launch, a wait while the 15 quotient bits are worked out, and a store. The
// result register is loaded as the step counter leaves PC_EMIT; PC_WRAP comes before
// PC_IDLE, where the next item can transfer, and that item is taken even if the result
// is still stalled; a new result waits only while the previous one is stalled.
module rgb_linear_fade_engine_unit import rlfe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  ctrl_word_t cw;

  logic [PC_W-1:0]           pc_r, pc_nxt;
  in_item_t                  item_r, item_nxt;
  logic [CH_W-1:0]           ch_r, ch_nxt;
  logic                      neg_r, neg_nxt;
  logic [COLOR_W-1:0]        shown_r [CHANNELS];
  logic [COLOR_W-1:0]        shown_nxt [CHANNELS];
  logic [ACC_W-1:0]          acc_r [CHANNELS];
  logic [ACC_W-1:0]          acc_nxt [CHANNELS];
  logic signed [INC_W-1:0]   inc_r [CHANNELS];
  logic signed [INC_W-1:0]   inc_nxt [CHANNELS];
  logic [COLOR_W-1:0]        final_r [CHANNELS];
  logic [COLOR_W-1:0]        final_nxt [CHANNELS];
  logic [STEP_W-1:0]         steps_left_r, steps_left_nxt;
  logic [DELAY_W-1:0]        ms_left_r, ms_left_nxt;
  logic [DELAY_W-1:0]        reload_r, reload_nxt;
  logic                      busy_r, busy_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_item_t                 out_data_r, out_data_nxt;

  logic                      div_start;
  logic                      div_busy;
  logic [DIV_W-1:0]          div_quo;
  logic [DIV_W-1:0]          div_dividend;
  logic signed [COLOR_W:0]   diff;
  logic [COLOR_W:0]          diff_mag;
  logic [DELAY_W-1:0]        delay_eff;
  logic                      take;
  logic signed [INC_W:0]     sum [CHANNELS];
  logic [ACC_W-1:0]          stepped [CHANNELS];

  assign cw = ucode_rom(pc_r);

  // Difference of the current channel, scaled by 128, split into sign and magnitude.
  always_comb begin
    diff         = $signed({1'b0, final_r[ch_r]}) - $signed({1'b0, shown_r[ch_r]});
    diff_mag     = diff[COLOR_W] ? (COLOR_W + 1)'(0) - diff : diff;
    div_dividend = {diff_mag[COLOR_W-1:0], {SCALE_SH{1'b0}}};
    div_start    = (cw.op == OP_DIV_GO);
  end

  rlfe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (item_r.fade_steps),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // One step on every channel: add the increment and clamp to the level range.
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      sum[c] = $signed({3'b000, acc_r[c]}) + (INC_W + 1)'(inc_r[c]);
      if (sum[c] < 0) begin
        stepped[c] = '0;
      end else if (sum[c] > $signed({3'b000, ACC_MAX})) begin
        stepped[c] = ACC_MAX;
      end else begin
        stepped[c] = sum[c][ACC_W-1:0];
      end
    end
  end

  assign delay_eff = (item_r.step_delay_ms == '0) ? DELAY_W'(1) : item_r.step_delay_ms;

  always_comb begin
    case (cw.cond)
      C_NEVER:       take = 1'b0;
      C_ALWAYS:      take = 1'b1;
      C_NO_ACCEPT:   take = !in_valid;
      C_TICK:        take = (item_r.opcode == OPC_TICK);
      C_ZERO_STEPS:  take = (item_r.fade_steps == '0);
      C_DIV_BUSY:    take = div_busy;
      C_CH_MORE:     take = (ch_r != CH_LAST);
      C_NOT_BUSY:    take = !busy_r;
      C_MS_NONZERO:  take = (ms_left_r != '0);
      C_STEPS_ZERO:  take = (steps_left_r == '0);
      C_OUT_BLOCKED: take = out_valid_r && out_stall;
      default:       take = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt         = take ? cw.target : pc_r + 1'b1;
    item_nxt       = item_r;
    ch_nxt         = ch_r;
    neg_nxt        = neg_r;
    shown_nxt      = shown_r;
    acc_nxt        = acc_r;
    inc_nxt        = inc_r;
    final_nxt      = final_r;
    steps_left_nxt = steps_left_r;
    ms_left_nxt    = ms_left_r;
    reload_nxt     = reload_r;
    busy_nxt       = busy_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;

    if (pc_r == PC_IDLE && in_valid) begin
      item_nxt = in_data;
    end

    case (cw.op)
      OP_LOAD: begin
        ch_nxt = '0;
        for (int c = 0; c < CHANNELS; c++) begin
          if (c == 0) begin
            final_nxt[c] = item_r.target_red;
          end else if (c == 1) begin
            final_nxt[c] = item_r.target_green;
          end else if (c == 2) begin
            final_nxt[c] = item_r.target_blue;
          end else begin
            final_nxt[c] = '0;
          end
        end
      end
      OP_DIV_GO: begin
        neg_nxt = diff[COLOR_W];
      end
      OP_STORE_INC: begin
        inc_nxt[ch_r] = neg_r ? INC_W'(0) - {2'b00, div_quo} : {2'b00, div_quo};
        acc_nxt[ch_r] = {shown_r[ch_r], {SCALE_SH{1'b0}}};
        ch_nxt        = (ch_r == CH_LAST) ? '0 : ch_r + 1'b1;
      end
      OP_ARM: begin
        for (int c = 0; c < CHANNELS; c++) begin
          acc_nxt[c]   = stepped[c];
          shown_nxt[c] = stepped[c][ACC_W-1:SCALE_SH];
        end
        steps_left_nxt = item_r.fade_steps - 1'b1;
        reload_nxt     = delay_eff;
        ms_left_nxt    = delay_eff;
        busy_nxt       = 1'b1;
      end
      OP_TICK_DEC: begin
        ms_left_nxt = ms_left_r - 1'b1;
      end
      OP_STEP: begin
        for (int c = 0; c < CHANNELS; c++) begin
          acc_nxt[c]   = stepped[c];
          shown_nxt[c] = stepped[c][ACC_W-1:SCALE_SH];
        end
        steps_left_nxt = steps_left_r - 1'b1;
        ms_left_nxt    = reload_r;
      end
      OP_SNAP: begin
        for (int c = 0; c < CHANNELS; c++) begin
          shown_nxt[c] = final_r[c];
          acc_nxt[c]   = {final_r[c], {SCALE_SH{1'b0}}};
        end
        busy_nxt       = 1'b0;
        steps_left_nxt = '0;
        ms_left_nxt    = '0;
      end
      default: begin
      end
    endcase

    // Load the result only once the output register is free; otherwise hold.
    if (cw.emit && !(out_valid_r && out_stall)) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      for (int c = 0; c < CHANNELS; c++) begin
        if (c == 0) out_data_nxt.red_level   = shown_r[c];
        if (c == 1) out_data_nxt.green_level = shown_r[c];
        if (c == 2) out_data_nxt.blue_level  = shown_r[c];
      end
      out_data_nxt.fading = busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= PC_IDLE;
      ch_r         <= '0;
      steps_left_r <= '0;
      ms_left_r    <= '0;
      reload_r     <= '0;
      busy_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        shown_r[c] <= '0;
        acc_r[c]   <= '0;
        inc_r[c]   <= '0;
        final_r[c] <= '0;
      end
    end else begin
      pc_r         <= pc_nxt;
      ch_r         <= ch_nxt;
      steps_left_r <= steps_left_nxt;
      ms_left_r    <= ms_left_nxt;
      reload_r     <= reload_nxt;
      busy_r       <= busy_nxt;
      out_valid_r  <= out_valid_nxt;
      shown_r      <= shown_nxt;
      acc_r        <= acc_nxt;
      inc_r        <= inc_nxt;
      final_r      <= final_nxt;
    end
    item_r     <= item_nxt;
    neg_r      <= neg_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (pc_r != PC_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for rgb_linear_fade_engine_unit: fade starts and 1 ms ticks.
// Drives a directed table, then random fade sequences, and checks each result against a
// local predictor or a typed row's levels. Depends on rlfe_pkg for item types and opcodes.
`timescale 1ns / 100ps

module tb_top;
  import rlfe_pkg::*;

  localparam int IN_W        = $bits(in_item_t);
  localparam int RAND_ITEMS  = 430;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 100;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  rgb_linear_fade_engine_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Stimulus table; typed rows carry their own expected levels.
  in_item_t  cmd_q[$];
  bit        typed_q[$];
  out_item_t typed_lv_q[$];
  int        n_directed;

  out_item_t level_q[$];
  int        n_in      = 0;
  int        n_out     = 0;
  int        n_starts  = 0;
  int        n_ticks   = 0;
  int        n_errors  = 0;
  bit        hold_req  = 1'b0;
  int        hold_cnt  = 0;

  // Fade predictor state.
  logic [COLOR_W-1:0]      shown_lv [CHANNELS];
  logic [ACC_W-1:0]        acc_lv   [CHANNELS];
  logic signed [INC_W-1:0] inc_lv   [CHANNELS];
  logic [COLOR_W-1:0]      goal_lv  [CHANNELS];
  logic [STEP_W-1:0]       steps_rem;
  logic [DELAY_W-1:0]      ms_rem;
  logic [DELAY_W-1:0]      ms_reload;
  logic                    fade_on;

  function automatic void fade_clear();
    for (int c = 0; c < CHANNELS; c++) begin
      shown_lv[c] = '0;
      acc_lv[c]   = '0;
      inc_lv[c]   = '0;
      goal_lv[c]  = '0;
    end
    steps_rem = '0;
    ms_rem    = '0;
    ms_reload = '0;
    fade_on   = 1'b0;
  endfunction

  function automatic void take_step();
    int sum;
    for (int c = 0; c < CHANNELS; c++) begin
      sum = int'(acc_lv[c]) + int'(inc_lv[c]);
      if (sum < 0) sum = 0;
      if (sum > int'(ACC_MAX)) sum = int'(ACC_MAX);
      acc_lv[c]   = ACC_W'(sum);
      shown_lv[c] = COLOR_W'(sum >> SCALE_SH);
    end
  endfunction

  function automatic void snap_to_goal();
    for (int c = 0; c < CHANNELS; c++) begin
      shown_lv[c] = goal_lv[c];
      acc_lv[c]   = ACC_W'(goal_lv[c]) << SCALE_SH;
    end
    fade_on   = 1'b0;
    steps_rem = '0;
    ms_rem    = '0;
  endfunction

  function automatic logic [COLOR_W-1:0] level_of(input int c);
    return (c < CHANNELS) ? shown_lv[c] : '0;
  endfunction

  function automatic out_item_t fade_predict(input in_item_t it);
    out_item_t          res;
    logic [DELAY_W-1:0] dly;
    int                 diff;
    if (it.opcode == OPC_START) begin
      dly = (it.step_delay_ms == '0) ? DELAY_W'(1) : it.step_delay_ms;
      for (int c = 0; c < CHANNELS; c++)
        goal_lv[c] = (c == 0) ? it.target_red :
                     (c == 1) ? it.target_green :
                     (c == 2) ? it.target_blue : '0;
      if (it.fade_steps == '0) begin
        snap_to_goal();
      end else begin
        for (int c = 0; c < CHANNELS; c++) begin
          diff      = (int'(goal_lv[c]) - int'(shown_lv[c])) * (1 << SCALE_SH);
          inc_lv[c] = INC_W'(diff / int'(it.fade_steps));
          acc_lv[c] = ACC_W'(shown_lv[c]) << SCALE_SH;
        end
        take_step();
        steps_rem = it.fade_steps - 1'b1;
        ms_reload = dly;
        ms_rem    = dly;
        fade_on   = 1'b1;
      end
    end else if (fade_on) begin
      ms_rem = ms_rem - 1'b1;
      if (ms_rem == '0) begin
        if (steps_rem != '0) begin
          take_step();
          steps_rem = steps_rem - 1'b1;
          ms_rem    = ms_reload;
        end else begin
          snap_to_goal();
        end
      end
    end
    res.red_level   = level_of(0);
    res.green_level = level_of(1);
    res.blue_level  = level_of(2);
    res.fading      = fade_on;
    return res;
  endfunction

  function automatic in_item_t fade_cmd(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b, input logic [7:0] steps,
                                        input logic [15:0] dly);
    in_item_t it;
    it.opcode        = OPC_START;
    it.target_red    = r;
    it.target_green  = g;
    it.target_blue   = b;
    it.fade_steps    = steps;
    it.step_delay_ms = dly;
    return it;
  endfunction

  function automatic in_item_t random_bits();
    return in_item_t'(IN_W'({$urandom(), $urandom()}));
  endfunction

  function automatic out_item_t levels(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b, input logic f);
    out_item_t lv;
    lv.red_level   = r;
    lv.green_level = g;
    lv.blue_level  = b;
    lv.fading      = f;
    return lv;
  endfunction

  function automatic void add_row(input in_item_t it, input bit typed, input out_item_t lv);
    cmd_q.push_back(it);
    typed_q.push_back(typed);
    typed_lv_q.push_back(lv);
  endfunction

  function automatic void add_tick();
    in_item_t it;
    it        = random_bits();
    it.opcode = OPC_TICK;
    add_row(it, 1'b0, '0);
  endfunction

  function automatic void build_directed();
    in_item_t tk;
    tk = '0;
    tk.opcode = OPC_TICK;
    // idle tick after reset, then zero-step snaps at both color extremes
    add_row(tk, 1'b1, levels(8'd0, 8'd0, 8'd0, 1'b0));
    add_row(fade_cmd(8'd255, 8'd255, 8'd255, 8'd0, 16'd0), 1'b1,
            levels(8'd255, 8'd255, 8'd255, 1'b0));
    add_row(fade_cmd(8'd0, 8'd0, 8'd0, 8'd0, 16'hFFFF), 1'b1, levels(8'd0, 8'd0, 8'd0, 1'b0));
    // one-step fade with zero delay: full jump, then a single tick ends it
    add_row(fade_cmd(8'd255, 8'd0, 8'd128, 8'd1, 16'd0), 1'b1,
            levels(8'd255, 8'd0, 8'd128, 1'b1));
    add_row(tk, 1'b1, levels(8'd255, 8'd0, 8'd128, 1'b0));
    // tick while idle, with every ignored field set
    add_row('1, 1'b1, levels(8'd255, 8'd0, 8'd128, 1'b0));
    add_row(fade_cmd(8'd0, 8'd255, 8'd0, 8'd255, 16'hFFFF), 1'b0, '0);
    add_row(tk, 1'b0, '0);
    add_row(tk, 1'b0, '0);
    // restart while fading, run to the snap and one idle tick past it
    add_row(fade_cmd(8'd10, 8'd20, 8'd30, 8'd3, 16'd2), 1'b0, '0);
    repeat (7) add_row(tk, 1'b0, '0);
    add_row(fade_cmd(8'd255, 8'd255, 8'd255, 8'd2, 16'd1), 1'b0, '0);
    repeat (3) add_row(tk, 1'b0, '0);
  endfunction

  function automatic void build_random();
    in_item_t it;
    int       kind;
    int       steps;
    int       dly;
    int       burst;
    while (cmd_q.size() < n_directed + RAND_ITEMS) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        // well-formed fade followed by enough ticks to finish it, sometimes cut short
        steps = ($urandom_range(29) == 0) ? 255 : $urandom_range(9);
        dly   = (steps == 255) ? $urandom_range(1) : $urandom_range(4);
        add_row(fade_cmd(8'($urandom_range(255)), 8'($urandom_range(255)),
                         8'($urandom_range(255)), 8'(steps), 16'(dly)), 1'b0, '0);
        burst = steps * ((dly == 0) ? 1 : dly) + $urandom_range(3);
        if ($urandom_range(9) == 0) burst = $urandom_range(burst);
        repeat (burst) add_tick();
      end else if (kind < 85) begin
        it        = random_bits();
        it.opcode = OPC_START;
        add_row(it, 1'b0, '0);
        repeat ($urandom_range(3)) add_tick();
      end else begin
        repeat ($urandom_range(1, 5)) add_tick();
      end
    end
    // drop the tail of the last burst beyond the item budget
    while (cmd_q.size() > n_directed + RAND_ITEMS) begin
      void'(cmd_q.pop_back());
      void'(typed_q.pop_back());
      void'(typed_lv_q.pop_back());
    end
  endfunction

  function automatic int phase_of(input int idx);
    return (idx < n_directed) ? 0 : ((idx - n_directed) / 60) % 4;
  endfunction

  function automatic int send_idle_pct(input int ph);
    return (ph == 1) ? 84 : (ph == 3) ? 6 : 0;
  endfunction

  function automatic int recv_stall_pct(input int ph);
    return (ph == 2) ? 84 : (ph == 3) ? 6 : 0;
  endfunction

  task automatic report(input string field, input int want, input int got);
    $display("%0t: mismatch on %s, expected %0h actual %0h", $time, field, want, got);
    n_errors++;
  endtask

  // Present one item at a falling edge and hold it until its transfer.
  task automatic send_item(input in_item_t it, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      in_data  <= random_bits();
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct(phase_of(n_in)));
    end
  end

  always @(posedge clk) begin : check_proc
    out_item_t want;
    out_item_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        want = fade_predict(in_data);
        if (typed_q[n_in]) want = typed_lv_q[n_in];
        level_q.push_back(want);
        if (in_data.opcode == OPC_START) n_starts++;
        else n_ticks++;
        n_in++;
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        n_out++;
        if (level_q.size() == 0) begin
          $display("%0t: unexpected result, actual %0h", $time, got);
          n_errors++;
        end else begin
          want = level_q.pop_front();
          if (got.red_level !== want.red_level)
            report("red_level", int'(want.red_level), int'(got.red_level));
          if (got.green_level !== want.green_level)
            report("green_level", int'(want.green_level), int'(got.green_level));
          if (got.blue_level !== want.blue_level)
            report("blue_level", int'(want.blue_level), int'(got.blue_level));
          if (got.fading !== want.fading)
            report("fading", int'(want.fading), int'(got.fading));
        end
      end
    end
  end

  initial begin
    fade_clear();
    build_directed();
    n_directed = cmd_q.size();
    build_random();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int i = 0; i < cmd_q.size(); i++) begin
      if (i == n_directed + 100) begin
        // hold the output for a long stretch while items keep coming
        in_valid <= 1'b0;
        @(posedge clk);
        hold_req = 1'b1;
        @(negedge clk);
      end
      if (i == n_directed + 200) begin
        // drain: wait for every pending result before the next transfer
        in_valid <= 1'b0;
        @(negedge clk);
        while (level_q.size() != 0) @(negedge clk);
      end
      send_item(cmd_q[i], send_idle_pct(phase_of(i)));
    end
    in_valid <= 1'b0;
    while (level_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    $display("Ran %0d items (%0d fade starts, %0d ticks) and checked %0d results,",
             n_in, n_starts, n_ticks, n_out);
    $display("across four idling phases, a long output hold-off and a full drain pause.");
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results still pending", level_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> rgb_linear_fade_engine_unit.f
hdl/rlfe_pkg.sv
hdl/rlfe_div.sv
hdl/rgb_linear_fade_engine_unit.sv
tb/tb_top.sv
